/* rtl/nlf_pkg.sv */
// ============================================================================
// nlf_pkg
// Types and constants shared by the normalized line equation core.
// ============================================================================
package nlf_pkg;

    localparam int COORD_W  = 32;
    localparam int MAG_W    = COORD_W + 1;
    localparam int NORM_W   = 31;
    localparam int FRAC_W   = 30;
    localparam int ROOT_W   = 32;
    localparam int RAD_W    = 64;
    localparam int SQREM_W  = 35;
    localparam int C_W      = 40;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0]    coef_a;
        logic signed [31:0]    coef_b;
        logic signed [C_W-1:0] coef_c;
        logic                  valid_res;
    } t_out_req;

    // Sideband that travels with each request through the cell chains.
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [NORM_W-1:0]         ma;
        logic [NORM_W-1:0]         mb;
        logic                      sa;
        logic                      sb;
        logic                      zero;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
    } t_sq;

    typedef struct packed {
        logic [ROOT_W-1:0] n;
        logic [ROOT_W-1:0] rem_a;
        logic [ROOT_W-1:0] rem_b;
        logic [NORM_W-1:0] qa;
        logic [NORM_W-1:0] qb;
    } t_dv;

endpackage

/* rtl/nlf_sqrt_cell.sv */
// ============================================================================
// nlf_sqrt_cell
// One digit of a restoring integer square root; consumes two radicand bits.
// ============================================================================
module nlf_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  nlf_pkg::t_sq   i_sq,
    input  nlf_pkg::t_side i_side,
    output logic          o_vld,
    output nlf_pkg::t_sq   o_sq,
    output nlf_pkg::t_side o_side
);

    logic                 r_vld;
    nlf_pkg::t_sq          r_sq;
    nlf_pkg::t_side        r_side;
    nlf_pkg::t_sq          n_sq;
    logic [nlf_pkg::SQREM_W+1:0] cur;
    logic [nlf_pkg::SQREM_W+1:0] trial;

    always_comb begin
        cur   = {i_sq.rem, i_sq.rad[2*IDX+1 -: 2]};
        trial = {{(nlf_pkg::SQREM_W - nlf_pkg::ROOT_W){1'b0}}, i_sq.root, 2'b01};
        n_sq  = i_sq;
        if (cur >= trial) begin
            n_sq.rem  = nlf_pkg::SQREM_W'(cur - trial);
            n_sq.root = {i_sq.root[nlf_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_sq.rem  = cur[nlf_pkg::SQREM_W-1:0];
            n_sq.root = {i_sq.root[nlf_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_sq   = r_sq;
    assign o_side = r_side;

endmodule

/* rtl/nlf_div_cell.sv */
// ============================================================================
// nlf_div_cell
// One quotient bit of two restoring divisions that share the divisor.
// ============================================================================
module nlf_div_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  nlf_pkg::t_dv   i_dv,
    input  nlf_pkg::t_side i_side,
    output logic          o_vld,
    output nlf_pkg::t_dv   o_dv,
    output nlf_pkg::t_side o_side
);

    logic                  r_vld;
    nlf_pkg::t_dv           r_dv;
    nlf_pkg::t_side         r_side;
    nlf_pkg::t_dv           n_dv;
    logic                  bit_a;
    logic                  bit_b;
    logic [nlf_pkg::ROOT_W:0] cur_a;
    logic [nlf_pkg::ROOT_W:0] cur_b;
    logic [nlf_pkg::ROOT_W:0] div;

    always_comb begin
        // Only the top cell sees a nonzero dividend bit: bit 0 of the magnitude.
        bit_a = (IDX == nlf_pkg::FRAC_W) ? i_side.ma[0] : 1'b0;
        bit_b = (IDX == nlf_pkg::FRAC_W) ? i_side.mb[0] : 1'b0;
        cur_a = {i_dv.rem_a, bit_a};
        cur_b = {i_dv.rem_b, bit_b};
        div   = {1'b0, i_dv.n};
        n_dv  = i_dv;
        if (cur_a >= div) begin
            n_dv.rem_a = nlf_pkg::ROOT_W'(cur_a - div);
            n_dv.qa    = {i_dv.qa[nlf_pkg::NORM_W-2:0], 1'b1};
        end else begin
            n_dv.rem_a = cur_a[nlf_pkg::ROOT_W-1:0];
            n_dv.qa    = {i_dv.qa[nlf_pkg::NORM_W-2:0], 1'b0};
        end
        if (cur_b >= div) begin
            n_dv.rem_b = nlf_pkg::ROOT_W'(cur_b - div);
            n_dv.qb    = {i_dv.qb[nlf_pkg::NORM_W-2:0], 1'b1};
        end else begin
            n_dv.rem_b = cur_b[nlf_pkg::ROOT_W-1:0];
            n_dv.qb    = {i_dv.qb[nlf_pkg::NORM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv   <= n_dv;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_dv   = r_dv;
    assign o_side = r_side;

endmodule

/* rtl/normalized_line_from_two_points_core.sv */
// ============================================================================
// normalized_line_from_two_points_core
// Normalized line a*x + b*y + c = 0 through two Q16.16 vertices.
// ============================================================================
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+-------------------------
//  input    | in        | i_in_valid / o_in_ready     | i_in_req  (t_in_req)
//  output   | out       | o_out_valid / i_out_ready   | o_out_req (t_out_req)
//  config   | in        | i_cfg_we (no wait)          | i_cfg_wdata (winding)
//
// The core takes one request per cycle while the output is not stalled and
// returns one result per request, in order. The pipeline holds the 32
// square root cells and the 31 divider cells plus nine setup and multiply stages.
// Reset is synchronous and active low; it empties the pipeline and clears
// the winding register to counter-clockwise.
// The whole pipeline advances together; it stalls only while the output
// register holds a result that the consumer has not yet taken.
// ============================================================================
module normalized_line_from_two_points_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nlf_pkg::t_in_req   i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nlf_pkg::t_out_req  o_out_req
);

    localparam int SQ_CELLS = nlf_pkg::ROOT_W;
    localparam int DV_CELLS = nlf_pkg::NORM_W;

    // Global advance: every stage moves when the output register can take data.
    logic en;
    logic r_winding;

    // Stage 1: raw coefficients with winding applied.
    logic                             r1_vld;
    logic signed [nlf_pkg::COORD_W+1:0] r1_ra, r1_rb;
    logic signed [nlf_pkg::COORD_W-1:0] r1_x1, r1_y1;
    logic signed [nlf_pkg::COORD_W+1:0] n1_ra, n1_rb;

    // Stage 2: magnitudes and leading one position of the larger.
    logic                           r2_vld;
    logic [nlf_pkg::MAG_W-1:0]       r2_ma, r2_mb;
    logic [5:0]                     r2_pos;
    logic                           r2_sa, r2_sb, r2_zero;
    logic signed [nlf_pkg::COORD_W-1:0] r2_x1, r2_y1;
    logic [nlf_pkg::MAG_W-1:0]       n2_ma, n2_mb, n2_m;
    logic [5:0]                     n2_pos;

    // Stage 3: normalized magnitudes, the larger in [2^30, 2^31) unless both are zero.
    logic           r3_vld;
    nlf_pkg::t_side  r3_side;
    nlf_pkg::t_side  n3_side;
    logic [63:0]    wide_a, wide_b;

    // Stage 4: squares. Stage 5: radicand.
    logic           r4_vld, r5_vld;
    nlf_pkg::t_side  r4_side, r5_side;
    logic [2*nlf_pkg::NORM_W-1:0] r4_sqa, r4_sqb;
    logic [nlf_pkg::RAD_W-1:0]    r5_rad;

    // Cell chains.
    logic           sq_vld  [SQ_CELLS+1];
    nlf_pkg::t_sq    sq_dat  [SQ_CELLS+1];
    nlf_pkg::t_side  sq_side [SQ_CELLS+1];
    logic           dv_vld  [DV_CELLS+1];
    nlf_pkg::t_dv    dv_dat  [DV_CELLS+1];
    nlf_pkg::t_side  dv_side [DV_CELLS+1];

    // Signed coefficients, products, sum and output.
    logic                r6_vld, r7_vld, r8_vld, r_out_vld;
    logic signed [31:0]  r6_a, r6_b, r7_a, r7_b, r8_a, r8_b;
    logic                r6_zero, r7_zero, r8_zero;
    logic signed [nlf_pkg::COORD_W-1:0] r6_x1, r6_y1;
    logic signed [63:0]  r7_pa, r7_pb;
    logic signed [64:0]  r8_sum;
    logic signed [65:0]  f, c_full;
    nlf_pkg::t_out_req    r_out;
    nlf_pkg::t_out_req    n_out;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_winding <= 1'b0;
        end else if (i_cfg_we) begin
            r_winding <= i_cfg_wdata;
        end
    end

    // Valid bits of the setup and tail stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= dv_vld[DV_CELLS];
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r_out_vld <= r8_vld;
        end
    end

    // Stage 1: a = y1 - y2, b = x2 - x1, both negated for clockwise order.
    always_comb begin
        n1_ra = (nlf_pkg::COORD_W+2)'(i_in_req.first_y) - (nlf_pkg::COORD_W+2)'(i_in_req.second_y);
        n1_rb = (nlf_pkg::COORD_W+2)'(i_in_req.second_x) - (nlf_pkg::COORD_W+2)'(i_in_req.first_x);
        if (r_winding) begin
            n1_ra = -n1_ra;
            n1_rb = -n1_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ra <= n1_ra;
            r1_rb <= n1_rb;
            r1_x1 <= i_in_req.first_x;
            r1_y1 <= i_in_req.first_y;
        end
    end

    // Stage 2: magnitudes and the position of the leading one.
    always_comb begin
        n2_ma  = nlf_pkg::MAG_W'(r1_ra[nlf_pkg::COORD_W+1] ? -r1_ra : r1_ra);
        n2_mb  = nlf_pkg::MAG_W'(r1_rb[nlf_pkg::COORD_W+1] ? -r1_rb : r1_rb);
        n2_m   = (n2_ma > n2_mb) ? n2_ma : n2_mb;
        n2_pos = '0;
        for (int i = 0; i < nlf_pkg::MAG_W; i++) begin
            if (n2_m[i]) begin
                n2_pos = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ma   <= n2_ma;
            r2_mb   <= n2_mb;
            r2_pos  <= n2_pos;
            r2_sa   <= r1_ra[nlf_pkg::COORD_W+1];
            r2_sb   <= r1_rb[nlf_pkg::COORD_W+1];
            r2_zero <= (r1_ra == '0) && (r1_rb == '0);
            r2_x1   <= r1_x1;
            r2_y1   <= r1_y1;
        end
    end

    // Stage 3: scale both magnitudes by the same power of two so the larger
    // one has its leading one at bit 30; low bits drop on a right shift.
    always_comb begin
        wide_a = 64'(r2_ma);
        wide_b = 64'(r2_mb);
        if (r2_pos >= 6'(nlf_pkg::FRAC_W)) begin
            wide_a = wide_a >> (r2_pos - 6'(nlf_pkg::FRAC_W));
            wide_b = wide_b >> (r2_pos - 6'(nlf_pkg::FRAC_W));
        end else begin
            wide_a = wide_a << (6'(nlf_pkg::FRAC_W) - r2_pos);
            wide_b = wide_b << (6'(nlf_pkg::FRAC_W) - r2_pos);
        end
        n3_side.x1   = r2_x1;
        n3_side.y1   = r2_y1;
        n3_side.ma   = wide_a[nlf_pkg::NORM_W-1:0];
        n3_side.mb   = wide_b[nlf_pkg::NORM_W-1:0];
        n3_side.sa   = r2_sa;
        n3_side.sb   = r2_sb;
        n3_side.zero = r2_zero;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= n3_side;
            r4_side <= r3_side;
            r5_side <= r4_side;
            r4_sqa  <= r3_side.ma * r3_side.ma;
            r4_sqb  <= r3_side.mb * r3_side.mb;
            r5_rad  <= nlf_pkg::RAD_W'(r4_sqa) + nlf_pkg::RAD_W'(r4_sqb);
        end
    end

    // Square root chain: the cell for the highest digit comes first.
    assign sq_vld[0]      = r5_vld;
    assign sq_dat[0].rad  = r5_rad;
    assign sq_dat[0].rem  = '0;
    assign sq_dat[0].root = '0;
    assign sq_side[0]     = r5_side;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        nlf_sqrt_cell #(
            .IDX (SQ_CELLS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[g]),
            .i_sq    (sq_dat[g]),
            .i_side  (sq_side[g]),
            .o_vld   (sq_vld[g+1]),
            .o_sq    (sq_dat[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // Divider chain: the quotients are ma * 2^30 / n and mb * 2^30 / n.
    assign dv_vld[0]       = sq_vld[SQ_CELLS];
    assign dv_dat[0].n     = sq_dat[SQ_CELLS].root;
    assign dv_dat[0].rem_a = nlf_pkg::ROOT_W'(sq_side[SQ_CELLS].ma[nlf_pkg::NORM_W-1:1]);
    assign dv_dat[0].rem_b = nlf_pkg::ROOT_W'(sq_side[SQ_CELLS].mb[nlf_pkg::NORM_W-1:1]);
    assign dv_dat[0].qa    = '0;
    assign dv_dat[0].qb    = '0;
    assign dv_side[0]      = sq_side[SQ_CELLS];

    for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
        nlf_div_cell #(
            .IDX (DV_CELLS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[g]),
            .i_dv    (dv_dat[g]),
            .i_side  (dv_side[g]),
            .o_vld   (dv_vld[g+1]),
            .o_dv    (dv_dat[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // Tail: restore signs, form a*x1 + b*y1 exactly, then truncate the
    // offset toward zero, negate and saturate it; a degenerate request gives zeros.
    always_comb begin
        f = r8_sum >>> nlf_pkg::FRAC_W;
        if (r8_sum < 0 && r8_sum[nlf_pkg::FRAC_W-1:0] != '0) begin
            f = f + 66'sd1;
        end
        c_full = -f;
        n_out.coef_a    = r8_a;
        n_out.coef_b    = r8_b;
        n_out.valid_res = 1'b1;
        if (c_full > 66'sd549755813887) begin
            n_out.coef_c = {1'b0, {(nlf_pkg::C_W-1){1'b1}}};
        end else if (c_full < -66'sd549755813888) begin
            n_out.coef_c = {1'b1, {(nlf_pkg::C_W-1){1'b0}}};
        end else begin
            n_out.coef_c = c_full[nlf_pkg::C_W-1:0];
        end
        if (r8_zero) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_a    <= dv_side[DV_CELLS].sa ? -$signed({1'b0, dv_dat[DV_CELLS].qa})
                                             :  $signed({1'b0, dv_dat[DV_CELLS].qa});
            r6_b    <= dv_side[DV_CELLS].sb ? -$signed({1'b0, dv_dat[DV_CELLS].qb})
                                             :  $signed({1'b0, dv_dat[DV_CELLS].qb});
            r6_zero <= dv_side[DV_CELLS].zero;
            r6_x1   <= dv_side[DV_CELLS].x1;
            r6_y1   <= dv_side[DV_CELLS].y1;
            r7_pa   <= r6_a * r6_x1;
            r7_pb   <= r6_b * r6_y1;
            r7_a    <= r6_a;
            r7_b    <= r6_b;
            r7_zero <= r6_zero;
            r8_sum  <= 65'(r7_pa) + 65'(r7_pb);
            r8_a    <= r7_a;
            r8_b    <= r7_b;
            r8_zero <= r7_zero;
            r_out   <= n_out;
        end
    end

endmodule

/* rtl/nlf_checker.sv */
// ============================================================================
// nlf_checker
// Port-level checks on the normalized line equation core.
// ============================================================================
module nlf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input nlf_pkg::t_out_req o_out_req
);

    // A result that has not been taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("output request changed while stalled");

    // The core accepts input whenever its output side is free.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input not ready while output free");

    // A degenerate result carries all-zero coefficients.
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.valid_res |->
            o_out_req.coef_a == '0 && o_out_req.coef_b == '0 && o_out_req.coef_c == '0)
        else $error("degenerate result with nonzero coefficients");

    // Normalized coefficients never exceed one in Q1.30.
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_req.coef_a <= 32'sd1073741824 && o_out_req.coef_a >= -32'sd1073741824 &&
            o_out_req.coef_b <= 32'sd1073741824 && o_out_req.coef_b >= -32'sd1073741824)
        else $error("coefficient out of range");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind normalized_line_from_two_points_core nlf_checker u_nlf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
